// File: hw/rtl/utf8ti_pkg.sv
// ----------------------------------------------------------------------------
// utf8ti_pkg
// Shared types and constants of the UTF-8 text indexer.
// ----------------------------------------------------------------------------
package utf8ti_pkg;

  // Largest accepted text length in bytes (byte counter is 24 bits and never wraps)
  localparam longint unsigned MAX_TEXT_BYTES = 64'd16777215;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [20:0] NEWLINE_CP   = 21'h00000A;
  localparam logic [20:0] MIN_CP_2BYTE = 21'h000080;
  localparam logic [20:0] MIN_CP_3BYTE = 21'h000800;
  localparam logic [20:0] MIN_CP_4BYTE = 21'h010000;
  localparam logic [20:0] SURR_LO      = 21'h00D800;
  localparam logic [20:0] SURR_HI      = 21'h00DFFF;
  localparam logic [20:0] MAX_CP       = 21'h10FFFF;

  typedef enum logic [1:0] {
    KIND_CODEPOINT = 2'd0,
    KIND_SUMMARY   = 2'd1,
    KIND_ERROR     = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_BAD_BYTE  = 3'd1,
    CAUSE_VALUE     = 3'd2,
    CAUSE_TRUNCATED = 3'd3,
    CAUSE_TOO_LONG  = 3'd4
  } error_cause_t;

  // One queue entry: a code point or error result, plus what the summary needs
  typedef struct packed {
    result_kind_t kind;
    error_cause_t cause;
    logic [20:0]  codepoint;
    logic [23:0]  cp_index;
    logic [23:0]  start_offset;
    logic [24:0]  line_value;
    logic         starts_line;
    logic         has_summary;
    logic [23:0]  sum_bytes;
  } queue_entry_t;

  // Queue fill status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// File: hw/rtl/utf8_text_indexer.sv
// ----------------------------------------------------------------------------
// utf8_text_indexer
// Strict streaming UTF-8 decoder that indexes code points, offsets and lines.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle while the result queue is not full.
// The decode front updates its counters in the cycle a byte arrives and
// hands each result to a four-entry queue; the back side drives a registered
// output stream. A byte that completes a code point, or raises an error, is
// one output transfer; a last byte that completes a code point is two (the
// code point and the summary). The front takes new bytes while earlier
// results still wait in the queue. Each result is written into a queue
// slot and then loaded into the output register.
module utf8_text_indexer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [2:0] error_cause, [23:3] codepoint,
                                  // [47:24] cp_index, [71:48] start_offset,
                                  // [96:72] line_value, [97] starts_line
  output logic [1:0]   m_tuser,   // [1:0] result_kind
  output logic         m_tlast    // run_end
);
  import utf8ti_pkg::*;

  logic          push;
  queue_entry_t  push_ent;
  logic          pop;
  queue_entry_t  head_ent;
  queue_status_t q_stat;

  utf8ti_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .push_ent (push_ent)
  );

  utf8ti_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head_ent (head_ent),
    .q_stat   (q_stat)
  );

  utf8ti_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_ent (head_ent),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("result queue overflow");

  // A summary always closes the run of its byte
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_SUMMARY) |-> m_tlast)
    else $error("summary without run_end");

  // An error result is alone and carries no code point
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_ERROR) |-> (m_tlast && m_tdata[23:3] == 21'd0))
    else $error("malformed error result");

  // A transferred code point without run_end is followed by its summary
  a_cp_then_summary: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser == KIND_CODEPOINT && !m_tlast)
      |=> (m_tvalid && m_tuser == KIND_SUMMARY))
    else $error("missing summary after last code point");

endmodule

// File: hw/rtl/utf8ti_front.sv
// ----------------------------------------------------------------------------
// utf8ti_front
// Accepts text bytes, runs the strict UTF-8 decode and position counters,
// and pushes one queue entry for every byte that produces a result.
// ----------------------------------------------------------------------------
module utf8ti_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [7:0] data_byte
  input  logic                     s_tlast,   // last_byte
  input  utf8ti_pkg::queue_status_t q_stat,
  output logic                     push,
  output utf8ti_pkg::queue_entry_t push_ent
);
  import utf8ti_pkg::*;

  logic [20:0] partial_value, partial_value_next;
  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [1:0]  seq_length, seq_length_next;
  logic [23:0] seq_start, seq_start_next;
  logic [23:0] byte_count, byte_count_next;
  logic [23:0] cp_count, cp_count_next;
  logic [24:0] line_no, line_no_next;
  logic        after_newline, after_newline_next;
  logic        discarding, discarding_next;

  logic        accept;
  logic [7:0]  b;
  logic        err;
  error_cause_t cause;
  logic        emit_cp;
  logic [20:0] cp_val;
  logic [23:0] cp_off;
  logic [20:0] v;
  logic        bad;
  logic        restart;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign v        = {partial_value[14:0], b[5:0]};

  // Decode and next state
  always_comb begin
    partial_value_next = partial_value;
    bytes_pending_next = bytes_pending;
    seq_length_next    = seq_length;
    seq_start_next     = seq_start;
    byte_count_next    = byte_count;
    cp_count_next      = cp_count;
    line_no_next       = line_no;
    after_newline_next = after_newline;
    discarding_next    = discarding;
    err     = 1'b0;
    cause   = CAUSE_NONE;
    emit_cp = 1'b0;
    cp_val  = '0;
    cp_off  = seq_start;
    bad     = 1'b0;
    restart = 1'b0;
    push     = 1'b0;
    push_ent = '0;

    if (accept) begin
      if (discarding) begin
        restart = s_tlast;
      end else if ({40'd0, byte_count} >= MAX_TEXT_BYTES) begin
        err   = 1'b1;
        cause = CAUSE_TOO_LONG;
      end else if (bytes_pending == 2'd0) begin
        // lead byte
        seq_start_next = byte_count;
        if (!b[7]) begin
          emit_cp = 1'b1;
          cp_val  = {13'd0, b};
          cp_off  = byte_count;
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
          if (s_tlast) begin
            err   = 1'b1;
            cause = CAUSE_TRUNCATED;
          end else begin
            byte_count_next = byte_count + 24'd1;
            if (b[7:5] == 3'b110) begin
              partial_value_next = {16'd0, b[4:0]};
              bytes_pending_next = 2'd1;
              seq_length_next    = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
              partial_value_next = {17'd0, b[3:0]};
              bytes_pending_next = 2'd2;
              seq_length_next    = 2'd2;
            end else begin
              partial_value_next = {18'd0, b[2:0]};
              bytes_pending_next = 2'd3;
              seq_length_next    = 2'd3;
            end
          end
        end else begin
          err   = 1'b1;
          cause = CAUSE_BAD_BYTE;
        end
      end else begin
        // continuation byte
        if (b[7:6] != 2'b10) begin
          err   = 1'b1;
          cause = CAUSE_BAD_BYTE;
        end else if (bytes_pending > 2'd1) begin
          if (s_tlast) begin
            err   = 1'b1;
            cause = CAUSE_TRUNCATED;
          end else begin
            partial_value_next = v;
            bytes_pending_next = bytes_pending - 2'd1;
            byte_count_next    = byte_count + 24'd1;
          end
        end else begin
          // final byte: overlong, surrogate and range checks
          unique case (seq_length)
            2'd1:    bad = v < MIN_CP_2BYTE;
            2'd2:    bad = (v < MIN_CP_3BYTE) || (v >= SURR_LO && v <= SURR_HI);
            default: bad = (v < MIN_CP_4BYTE) || (v > MAX_CP);
          endcase
          if (bad) begin
            err   = 1'b1;
            cause = CAUSE_VALUE;
          end else begin
            emit_cp = 1'b1;
            cp_val  = v;
            cp_off  = seq_start;
          end
        end
      end

      if (err) begin
        push                  = 1'b1;
        push_ent.kind         = KIND_ERROR;
        push_ent.cause        = cause;
        push_ent.cp_index     = cp_count;
        push_ent.start_offset = (bytes_pending != 2'd0) ? seq_start : byte_count;
        push_ent.line_value   = line_no;
        discarding_next       = 1'b1;
        bytes_pending_next    = 2'd0;
        restart               = s_tlast;
      end else if (emit_cp) begin
        push                  = 1'b1;
        push_ent.kind         = KIND_CODEPOINT;
        push_ent.cause        = CAUSE_NONE;
        push_ent.codepoint    = cp_val;
        push_ent.cp_index     = cp_count;
        push_ent.start_offset = cp_off;
        push_ent.line_value   = line_no;
        push_ent.starts_line  = after_newline;
        push_ent.has_summary  = s_tlast;
        push_ent.sum_bytes    = byte_count + 24'd1;
        byte_count_next       = byte_count + 24'd1;
        cp_count_next         = cp_count + 24'd1;
        if (cp_val == NEWLINE_CP) begin
          line_no_next       = line_no + 25'd1;
          after_newline_next = 1'b1;
        end else begin
          after_newline_next = 1'b0;
        end
        partial_value_next = '0;
        seq_length_next    = 2'd0;
        bytes_pending_next = 2'd0;
        restart            = s_tlast;
      end
    end

    // start-of-text state after a text's last byte
    if (restart) begin
      partial_value_next = '0;
      bytes_pending_next = 2'd0;
      seq_length_next    = 2'd0;
      seq_start_next     = '0;
      byte_count_next    = '0;
      cp_count_next      = '0;
      line_no_next       = '0;
      after_newline_next = 1'b1;
      discarding_next    = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      bytes_pending <= 2'd0;
      seq_length    <= 2'd0;
      seq_start     <= '0;
      byte_count    <= '0;
      cp_count      <= '0;
      line_no       <= '0;
      after_newline <= 1'b1;
      discarding    <= 1'b0;
    end else begin
      partial_value <= partial_value_next;
      bytes_pending <= bytes_pending_next;
      seq_length    <= seq_length_next;
      seq_start     <= seq_start_next;
      byte_count    <= byte_count_next;
      cp_count      <= cp_count_next;
      line_no       <= line_no_next;
      after_newline <= after_newline_next;
      discarding    <= discarding_next;
    end
  end

endmodule

// File: hw/rtl/utf8ti_queue.sv
// ----------------------------------------------------------------------------
// utf8ti_queue
// Small FIFO of result entries between the decode front and the output back.
// ----------------------------------------------------------------------------
module utf8ti_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  utf8ti_pkg::queue_entry_t  push_ent,
  input  logic                      pop,
  output utf8ti_pkg::queue_entry_t  head_ent,
  output utf8ti_pkg::queue_status_t q_stat
);
  import utf8ti_pkg::*;

  queue_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign q_stat.empty = (count == QCNT_W'(0));
  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_ent     = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/utf8ti_back.sv
// ----------------------------------------------------------------------------
// utf8ti_back
// Drains queue entries into the output register: one transfer per entry, or
// two when a code point on a text's last byte also carries the summary.
// ----------------------------------------------------------------------------
module utf8ti_back (
  input  logic                      clk,
  input  logic                      rst,
  input  utf8ti_pkg::queue_entry_t  head_ent,
  input  utf8ti_pkg::queue_status_t q_stat,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [103:0]              m_tdata,  // error_cause, codepoint, cp_index,
                                              // start_offset, line_value, starts_line
  output logic [1:0]                m_tuser,  // result_kind
  output logic                      m_tlast   // run_end
);
  import utf8ti_pkg::*;

  logic         summary_phase;
  logic         load;
  result_kind_t out_kind;
  error_cause_t out_cause;
  logic [20:0]  out_cp;
  logic [23:0]  out_idx;
  logic [23:0]  out_off;
  logic [24:0]  out_line;
  logic         out_sl;
  logic         out_last;
  logic [24:0]  sum_line;

  assign load = (!m_tvalid || m_tready) && !q_stat.empty;
  assign pop  = load && (summary_phase || !head_ent.has_summary);

  // line count: newlines so far plus one, counting this code point
  assign sum_line = head_ent.line_value +
                    ((head_ent.codepoint == NEWLINE_CP) ? 25'd2 : 25'd1);

  // Output valid and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      summary_phase <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid      <= 1'b1;
        summary_phase <= !summary_phase && head_ent.has_summary;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (summary_phase) begin
        out_kind  <= KIND_SUMMARY;
        out_cause <= CAUSE_NONE;
        out_cp    <= '0;
        out_idx   <= head_ent.cp_index + 24'd1;
        out_off   <= head_ent.sum_bytes;
        out_line  <= sum_line;
        out_sl    <= 1'b0;
        out_last  <= 1'b1;
      end else begin
        out_kind  <= head_ent.kind;
        out_cause <= head_ent.cause;
        out_cp    <= head_ent.codepoint;
        out_idx   <= head_ent.cp_index;
        out_off   <= head_ent.start_offset;
        out_line  <= head_ent.line_value;
        out_sl    <= head_ent.starts_line;
        out_last  <= !head_ent.has_summary;
      end
    end
  end

  assign m_tdata = {6'd0, out_sl, out_line, out_off, out_idx, out_cp, out_cause};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

// File: tb/tb_utf8_text_indexer.sv
// ----------------------------------------------------------------------------
// tb_utf8_text_indexer
// Self-checking testbench for the streaming UTF-8 decoder and text indexer.
// ----------------------------------------------------------------------------
// Texts are fed one byte per transfer. A short directed part covers the value
// extremes and each error path but the text-length limit. A random part follows:
// mostly well-formed texts built from random code points, some with one broken sequence inside.
// A decode model in this file predicts every output transfer at the moment a
// byte is taken. A monitor compares each output transfer, field by field,
// with the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_text_indexer;
  import utf8ti_pkg::*;

  // One predicted output transfer
  typedef struct packed {
    result_kind_t kind;
    error_cause_t cause;
    logic [20:0]  cp;
    logic [23:0]  cp_idx;
    logic [23:0]  offs;
    logic [24:0]  line;
    logic         first_in_line;
    logic         run_end;
  } index_result_t;

  // One byte waiting to be sent
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain_first;  // wait for all results before sending
  } text_byte_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  text_byte_t    byte_q[$];
  logic [7:0]    text_buf[$];
  index_result_t expected_q[$];

  int bytes_queued = 0;
  int bytes_taken = 0;
  int fail_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int calm_count = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;

  // Decoder state of the prediction
  logic [20:0] dec_partial;
  logic [1:0]  dec_pending;
  logic [1:0]  dec_seqlen;
  logic [23:0] dec_seq_start;
  logic [23:0] dec_bytes;
  logic [23:0] dec_cps;
  logic [24:0] dec_line;
  logic        dec_at_line_start;
  logic        dec_dropping;

  utf8_text_indexer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic void text_clear();
    dec_partial       = '0;
    dec_pending       = '0;
    dec_seqlen        = '0;
    dec_seq_start     = '0;
    dec_bytes         = '0;
    dec_cps           = '0;
    dec_line          = '0;
    dec_at_line_start = 1'b1;
    dec_dropping      = 1'b0;
  endfunction

  function automatic void push_result(input result_kind_t kind, input error_cause_t cause,
                                      input logic [20:0] cp, input logic [23:0] cp_idx,
                                      input logic [23:0] offs, input logic [24:0] line,
                                      input logic first_in_line, input logic run_end);
    index_result_t r;
    r.kind          = kind;
    r.cause         = cause;
    r.cp            = cp;
    r.cp_idx        = cp_idx;
    r.offs          = offs;
    r.line          = line;
    r.first_in_line = first_in_line;
    r.run_end       = run_end;
    expected_q.push_back(r);
  endfunction

  // Error result; the rest of the text is dropped unless this was its last byte
  function automatic void flag_error(input error_cause_t cause, input logic last);
    logic [23:0] offs;
    offs = (dec_pending != 0) ? dec_seq_start : dec_bytes;
    push_result(KIND_ERROR, cause, '0, dec_cps, offs, dec_line, 1'b0, 1'b1);
    if (last) begin
      text_clear();
    end else begin
      dec_dropping = 1'b1;
      dec_pending  = '0;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic bad;
    if (dec_dropping) begin
      if (last) text_clear();
      return;
    end
    if (64'(dec_bytes) >= MAX_TEXT_BYTES) begin
      flag_error(CAUSE_TOO_LONG, last);
      return;
    end
    if (dec_pending == 0) begin
      // lead byte
      dec_seq_start = dec_bytes;
      if (!b[7]) begin
        dec_partial = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        dec_partial = {16'd0, b[4:0]};
        dec_pending = 2'd1;
        dec_seqlen  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        dec_partial = {17'd0, b[3:0]};
        dec_pending = 2'd2;
        dec_seqlen  = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        dec_partial = {18'd0, b[2:0]};
        dec_pending = 2'd3;
        dec_seqlen  = 2'd3;
      end else begin
        flag_error(CAUSE_BAD_BYTE, last);
        return;
      end
      if (dec_pending != 0) begin
        if (last) begin
          flag_error(CAUSE_TRUNCATED, last);
          return;
        end
        dec_bytes = dec_bytes + 24'd1;
        return;
      end
    end else begin
      // continuation byte
      if (b[7:6] != 2'b10) begin
        flag_error(CAUSE_BAD_BYTE, last);
        return;
      end
      dec_partial = {dec_partial[14:0], b[5:0]};
      if (dec_pending > 1) begin
        if (last) begin
          flag_error(CAUSE_TRUNCATED, last);
          return;
        end
        dec_pending = dec_pending - 2'd1;
        dec_bytes   = dec_bytes + 24'd1;
        return;
      end
      case (dec_seqlen)
        2'd1:    bad = dec_partial < MIN_CP_2BYTE;
        2'd2:    bad = dec_partial < MIN_CP_3BYTE ||
                       (dec_partial >= SURR_LO && dec_partial <= SURR_HI);
        default: bad = dec_partial < MIN_CP_4BYTE || dec_partial > MAX_CP;
      endcase
      if (bad) begin
        flag_error(CAUSE_VALUE, last);
        return;
      end
      dec_pending = '0;
    end

    // code point complete
    push_result(KIND_CODEPOINT, CAUSE_NONE, dec_partial, dec_cps, dec_seq_start, dec_line,
                dec_at_line_start, !last);
    dec_bytes = dec_bytes + 24'd1;
    dec_cps   = dec_cps + 24'd1;
    if (dec_partial == NEWLINE_CP) begin
      dec_line          = dec_line + 25'd1;
      dec_at_line_start = 1'b1;
    end else begin
      dec_at_line_start = 1'b0;
    end
    dec_partial = '0;
    dec_seqlen  = '0;
    if (last) begin
      push_result(KIND_SUMMARY, CAUSE_NONE, '0, dec_cps, dec_bytes, dec_line + 25'd1,
                  1'b0, 1'b1);
      text_clear();
    end
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus building
  // ------------------------------------------------------------------------
  function automatic void put(input logic [7:0] b);
    text_buf.push_back(b);
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Move the text into the send queue, last flag on its final byte
  function automatic void close_text(input logic drain_first);
    text_byte_t tb;
    for (int i = 0; i < text_buf.size(); i++) begin
      tb.data        = text_buf[i];
      tb.last        = (i == text_buf.size() - 1);
      tb.drain_first = drain_first && (i == 0);
      byte_q.push_back(tb);
    end
    bytes_queued += text_buf.size();
    text_buf.delete();
  endfunction

  function automatic void put_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put(cp[7:0]);
    end else if (cp < 21'h800) begin
      put({3'b110, cp[10:6]});
      put({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put({4'b1110, cp[15:12]});
      put({2'b10, cp[11:6]});
      put({2'b10, cp[5:0]});
    end else begin
      put({5'b11110, cp[20:18]});
      put({2'b10, cp[17:12]});
      put({2'b10, cp[11:6]});
      put({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic [20:0] random_cp();
    int unsigned r;
    case ($urandom_range(0, 9))
      0, 1, 2: r = $urandom_range(0, 'h7F);
      3:       r = 'h0A;
      4, 5:    r = $urandom_range('h80, 'h7FF);
      6, 7: begin
        // skip the surrogate range
        r = $urandom_range('h800, 'hF7FF);
        if (r >= 'hD800) r += 'h800;
      end
      default: r = $urandom_range('h10000, 'h10FFFF);
    endcase
    return 21'(r);
  endfunction

  // One broken sequence; returns 1 when the text should end right here
  function automatic bit put_broken();
    int len;
    int conts;
    case ($urandom_range(0, 7))
      0: put(8'($urandom_range(0, 255)));
      1: put(rand_cont());                       // stray continuation
      2: put(8'($urandom_range('hF8, 'hFF)));    // invalid lead
      3: begin                                   // overlong forms
        case ($urandom_range(0, 2))
          0: begin
            put(8'($urandom_range('hC0, 'hC1)));
            put(rand_cont());
          end
          1: begin
            put(8'hE0);
            put(8'($urandom_range('h80, 'h9F)));
            put(rand_cont());
          end
          default: begin
            put(8'hF0);
            put(8'($urandom_range('h80, 'h8F)));
            put(rand_cont());
            put(rand_cont());
          end
        endcase
      end
      4: begin                                   // surrogate
        put(8'hED);
        put(8'($urandom_range('hA0, 'hBF)));
        put(rand_cont());
      end
      5: begin                                   // above 10FFFF
        if ($urandom_range(0, 1) == 0) begin
          put(8'hF4);
          put(8'($urandom_range('h90, 'hBF)));
        end else begin
          put(8'($urandom_range('hF5, 'hF7)));
          put(rand_cont());
        end
        put(rand_cont());
        put(rand_cont());
      end
      6: begin                                   // continuation missing mid-text
        len = $urandom_range(1, 3);
        put(len == 1 ? 8'($urandom_range('hC2, 'hDF)) :
            len == 2 ? 8'($urandom_range('hE1, 'hEC)) : 8'($urandom_range('hF1, 'hF3)));
        conts = $urandom_range(0, len - 1);
        for (int i = 0; i < conts; i++) put(rand_cont());
        put($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F))
                                 : 8'($urandom_range('hC0, 'hFF)));
      end
      default: begin                             // cut short by the end of text
        len = $urandom_range(1, 3);
        put(len == 1 ? 8'($urandom_range('hC2, 'hDF)) :
            len == 2 ? 8'($urandom_range('hE1, 'hEC)) : 8'($urandom_range('hF1, 'hF3)));
        conts = $urandom_range(0, len - 1);
        for (int i = 0; i < conts; i++) put(rand_cont());
        return 1'b1;
      end
    endcase
    return $urandom_range(0, 3) == 0;
  endfunction

  function automatic void make_random_text(input logic drain_first);
    int  n_cp;
    bit  noisy;
    int  bad_at;
    n_cp   = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
    noisy  = $urandom_range(0, 99) < 25;
    bad_at = $urandom_range(0, n_cp - 1);
    for (int i = 0; i < n_cp; i++) begin
      if (noisy && i == bad_at) begin
        if (put_broken()) break;
      end
      put_cp(random_cp());
    end
    close_text(drain_first);
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_idle(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ------------------------------------------------------------------------
  // Calm stretches with no idling, drawn for each side on its own
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    calm_count <= calm_count + 1;
    if (calm_count % 128 == 0) begin
      src_calm  <= $urandom_range(0, 3) == 0;
      sink_calm <= $urandom_range(0, 3) == 0;
    end
  end

  // ------------------------------------------------------------------------
  // Driver
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    logic       next_valid;
    text_byte_t nb;
    if (rst) begin
      s_tvalid <= 1'b0;
      text_clear();
    end else begin
      next_valid = s_tvalid && !s_tready;
      // byte taken this edge: predict its results
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tlast);
        bytes_taken++;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (byte_q.size() != 0 &&
                     !(byte_q[0].drain_first && expected_q.size() != 0)) begin
          nb = byte_q.pop_front();
          s_tdata    <= nb.data;
          s_tlast    <= nb.last;
          next_valid = 1'b1;
          send_gap   = pick_idle(src_calm);
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // ------------------------------------------------------------------------
  // Monitor
  // ------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    index_result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual tuser %0h tdata %h",
                   $time, m_tuser, m_tdata);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("result_kind", 32'(exp_r.kind), 32'(m_tuser));
          check_field("error_cause", 32'(exp_r.cause), 32'(m_tdata[2:0]));
          check_field("codepoint", 32'(exp_r.cp), 32'(m_tdata[23:3]));
          check_field("cp_index", 32'(exp_r.cp_idx), 32'(m_tdata[47:24]));
          check_field("start_offset", 32'(exp_r.offs), 32'(m_tdata[71:48]));
          check_field("line_value", 32'(exp_r.line), 32'(m_tdata[96:72]));
          check_field("starts_line", 32'(exp_r.first_in_line), 32'(m_tdata[97]));
          check_field("tdata padding", 32'd0, 32'(m_tdata[103:98]));
          check_field("run_end", 32'(exp_r.run_end), 32'(m_tlast));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_idle(sink_calm);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus and end of run
  // ------------------------------------------------------------------------
  initial begin
    int text_no;
    // extremes of single code points, largest scalar value, summary
    put(8'h00); put(8'h0A); put(8'h7F); put(8'hDF); put(8'hBF);
    put(8'hF4); put(8'h8F); put(8'hBF); put(8'hBF);
    close_text(1'b0);
    // surrogate, then the rest of the text dropped
    put(8'hED); put(8'hA0); put(8'h80); put(8'h41);
    close_text(1'b0);
    // above the scalar range, error on the last byte
    put(8'hF4); put(8'h90); put(8'h80); put(8'h80);
    close_text(1'b0);
    // invalid lead as the only byte
    put(8'hFF);
    close_text(1'b0);
    // bad continuation on the last byte
    put(8'hE0); put(8'h41);
    close_text(1'b0);
    // truncated inside a sequence and at its lead
    put(8'hF0); put(8'h90);
    close_text(1'b0);
    put(8'hC3);
    close_text(1'b0);

    // random texts; every fifteenth waits for the output to drain first
    text_no = 0;
    while (bytes_queued < 440) begin
      make_random_text(text_no % 15 == 0);
      text_no++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != bytes_queued) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/utf8ti_pkg.sv
hw/rtl/utf8ti_front.sv
hw/rtl/utf8ti_queue.sv
hw/rtl/utf8ti_back.sv
hw/rtl/utf8_text_indexer.sv
tb/tb_utf8_text_indexer.sv
